@@ design/hyst_pkg.sv @@
// shared types and constants for the hysteresis edge tracking block
// no dependencies; compiled before every other file of the block
package hyst_pkg;

   // field widths fixed by the block's interface
   localparam int COORD_W    = 9;
   localparam int CLASS_W    = 2;
   localparam int COUNT_W    = 19;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_DATA_W-1:0] ACTIVE_RESET = 10'd512;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_HEIGHT = 1'b1;

   typedef logic [CLASS_W-1:0] class_type;

   localparam class_type CLS_STRONG   = 2'd0;
   localparam class_type CLS_WEAK     = 2'd1;
   localparam class_type CLS_MID      = 2'd2;
   localparam class_type CLS_RESERVED = 2'd3;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_SEED  = 2'd1,
      MODE_RUN   = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   // controller to datapath
   typedef struct packed {
      logic accept;     // request transaction taken this cycle
      logic load_read;  // present store read data as the response
      logic pop;        // read the queue head
      logic center;     // mark popped pixel strong, set up neighbourhood
      logic nb_read;    // read current neighbour
      logic nb_eval;    // promote current neighbour if mid, step on
      logic run_done;   // present promotion count, clear the queue
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_valid;
      logic is_run;
      logic is_read_hit;
      logic q_empty;
      logic nb_empty;
      logic nb_last;
   } stat_type;

endpackage

@@ design/hyst_req_if.sv @@
// request channel of the hysteresis edge tracking block
// depends on hyst_pkg for field widths
interface hyst_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     mode;
   logic [hyst_pkg::COORD_W-1:0]   x_coord;
   logic [hyst_pkg::COORD_W-1:0]   y_coord;
   logic [hyst_pkg::CLASS_W-1:0]   pixel_class;

   modport source (output valid, mode, x_coord, y_coord, pixel_class, input ready);
   modport sink   (input valid, mode, x_coord, y_coord, pixel_class, output ready);
endinterface

@@ design/hyst_rsp_if.sv @@
// response channel of the hysteresis edge tracking block
// depends on hyst_pkg for field widths
interface hyst_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hyst_pkg::CLASS_W-1:0]   read_class;
   logic [hyst_pkg::COUNT_W-1:0]   promoted_count;
   logic                           status;

   modport source (output valid, read_class, promoted_count, status, input ready);
   modport sink   (input valid, read_class, promoted_count, status, output ready);
endinterface

@@ design/hyst_ctrl.sv @@
// controller state machine of the hysteresis edge tracking block
// depends on hyst_pkg for the command and status structs
module hyst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               rsp_ready,
   input  hyst_pkg::stat_type stat,
   output logic               req_ready,
   output hyst_pkg::cmd_type  cmd
);
   import hyst_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_READ_WAIT = 6'b000010,
      ST_POP       = 6'b000100,
      ST_CENTER    = 6'b001000,
      ST_NB_READ   = 6'b010000,
      ST_NB_EVAL   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // controller idle, and output slot is free or is being emptied this cycle
   assign req_ready = (state_ff == ST_IDLE) && (!stat.rsp_valid || rsp_ready);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               if (stat.is_run) begin
                  state_in = ST_POP;
               end else if (stat.is_read_hit) begin
                  state_in = ST_READ_WAIT;
               end
            end
         end
         ST_READ_WAIT: begin
            cmd.load_read = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_POP: begin
            if (stat.q_empty) begin
               cmd.run_done = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_CENTER;
            end
         end
         ST_CENTER: begin
            cmd.center = 1'b1;
            state_in   = stat.nb_empty ? ST_POP : ST_NB_READ;
         end
         ST_NB_READ: begin
            cmd.nb_read = 1'b1;
            state_in    = ST_NB_EVAL;
         end
         ST_NB_EVAL: begin
            cmd.nb_eval = 1'b1;
            state_in    = stat.nb_last ? ST_POP : ST_NB_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/hyst_dp.sv @@
// datapath of the hysteresis edge tracking block: class store, work queue,
// neighbourhood walker, configuration and response registers; uses hyst_pkg
module hyst_dp #(
   parameter int MAX_COLUMNS = 512,
   parameter int MAX_ROWS    = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hyst_pkg::cmd_type                   cmd,
   input  logic [1:0]                          req_mode,
   input  logic [hyst_pkg::COORD_W-1:0]        req_x,
   input  logic [hyst_pkg::COORD_W-1:0]        req_y,
   input  logic [hyst_pkg::CLASS_W-1:0]        req_class,
   input  logic                                csr_we,
   input  logic [hyst_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hyst_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                rsp_ready,
   output hyst_pkg::stat_type                  stat,
   output logic                                rsp_valid,
   output logic [hyst_pkg::CLASS_W-1:0]        rsp_read_class,
   output logic [hyst_pkg::COUNT_W-1:0]        rsp_promoted_count,
   output logic                                rsp_status
);
   import hyst_pkg::*;

   localparam int XW     = $clog2(MAX_COLUMNS);
   localparam int YW     = $clog2(MAX_ROWS);
   localparam int AW     = XW + YW;
   localparam int XE     = XW + 1;
   localparam int YE     = YW + 1;
   localparam int PIXELS = MAX_COLUMNS * MAX_ROWS;
   localparam int QPW    = $clog2(PIXELS);
   localparam int QCW    = $clog2(PIXELS + 1);
   localparam int XCW    = (XE > COORD_W) ? XE : COORD_W;
   localparam int YCW    = (YE > COORD_W) ? YE : COORD_W;
   localparam int WCW    = (XE > CSR_DATA_W) ? XE : CSR_DATA_W;
   localparam int HCW    = (YE > CSR_DATA_W) ? YE : CSR_DATA_W;

   // configuration
   logic [CSR_DATA_W-1:0] width_ff, height_ff;
   logic [XE-1:0]         w_eff;
   logic [YE-1:0]         h_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ACTIVE_RESET;
         height_ff <= ACTIVE_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_ACTIVE_WIDTH) begin
            width_ff <= csr_wdata;
         end else if (csr_index == CSR_ACTIVE_HEIGHT) begin
            height_ff <= csr_wdata;
         end
      end
   end

   // clamp to 1 .. max
   always_comb begin
      if (width_ff == '0) begin
         w_eff = XE'(1);
      end else if (WCW'(width_ff) > WCW'(MAX_COLUMNS)) begin
         w_eff = XE'(MAX_COLUMNS);
      end else begin
         w_eff = XE'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = YE'(1);
      end else if (HCW'(height_ff) > HCW'(MAX_ROWS)) begin
         h_eff = YE'(MAX_ROWS);
      end else begin
         h_eff = YE'(height_ff);
      end
   end

   // request decode
   logic          in_range, is_write, is_seed, is_run, is_read;
   logic [AW-1:0] req_addr;
   class_type     wr_class;

   assign in_range = (XCW'(req_x) < XCW'(w_eff)) && (YCW'(req_y) < YCW'(h_eff));
   assign is_write = (req_mode == MODE_WRITE);
   assign is_seed  = (req_mode == MODE_SEED);
   assign is_run   = (req_mode == MODE_RUN);
   assign is_read  = (req_mode == MODE_READ);
   assign req_addr = {YW'(req_y), XW'(req_x)};
   // code three is kept as weak
   assign wr_class = (req_class == CLS_RESERVED) ? CLS_WEAK : req_class;

   // work queue
   logic [AW-1:0]  q_mem [PIXELS];
   logic [AW-1:0]  q_rdata_ff;
   logic [QPW-1:0] head_ff, tail_ff;
   logic [QCW-1:0] count_ff;
   logic           q_full, q_push;
   logic [AW-1:0]  q_wdata;

   // neighbourhood walker
   logic [XW-1:0] j_ff, xe_ff;
   logic [YW-1:0] k_ff, y0_ff, ye_ff;
   logic [AW-1:0] nb_addr;
   logic          nb_mid;

   // class store
   class_type     store_mem [2**AW];
   class_type     s_rdata_ff;
   logic          s_we, s_re;
   logic [AW-1:0] s_waddr, s_raddr;
   class_type     s_wdata;

   logic [COUNT_W-1:0] promoted_ff;

   assign nb_addr = {k_ff, j_ff};
   assign nb_mid  = cmd.nb_eval && (s_rdata_ff == CLS_MID);
   assign q_full  = (count_ff >= QCW'(PIXELS));

   // centre pixel and neighbourhood bounds from the popped entry
   logic [XW-1:0] cx, x0, xe;
   logic [YW-1:0] cy, y0, ye;
   logic [XE-1:0] xp2, x1;
   logic [YE-1:0] yp2, y1;

   always_comb begin
      cx  = q_rdata_ff[XW-1:0];
      cy  = q_rdata_ff[AW-1:XW];
      x0  = (cx == '0) ? '0 : cx - XW'(1);
      y0  = (cy == '0) ? '0 : cy - YW'(1);
      xp2 = XE'(cx) + XE'(2);
      yp2 = YE'(cy) + YE'(2);
      x1  = (xp2 < w_eff) ? xp2 : w_eff;
      y1  = (yp2 < h_eff) ? yp2 : h_eff;
      xe  = XW'(x1 - XE'(1));
      ye  = YW'(y1 - YE'(1));
   end

   // store port selection
   always_comb begin
      s_we    = 1'b0;
      s_waddr = req_addr;
      s_wdata = CLS_STRONG;
      priority if (cmd.accept && in_range && is_write) begin
         s_we    = 1'b1;
         s_wdata = wr_class;
      end else if (cmd.accept && in_range && is_seed) begin
         s_we    = 1'b1;
      end else if (cmd.center) begin
         s_we    = 1'b1;
         s_waddr = q_rdata_ff;
      end else if (nb_mid) begin
         s_we    = 1'b1;
         s_waddr = nb_addr;
      end else begin
         s_we    = 1'b0;
      end
   end

   assign s_re    = (cmd.accept && in_range && is_read) || cmd.nb_read;
   assign s_raddr = cmd.nb_read ? nb_addr : req_addr;

   always_ff @(posedge clock) begin
      if (s_we) begin
         store_mem[s_waddr] <= s_wdata;
      end
      if (s_re) begin
         s_rdata_ff <= store_mem[s_raddr];
      end
   end

   // a push onto a full queue is dropped
   assign q_push  = !q_full && ((cmd.accept && in_range && is_seed) || nb_mid);
   assign q_wdata = cmd.nb_eval ? nb_addr : req_addr;

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem[tail_ff] <= q_wdata;
      end
      if (cmd.pop) begin
         q_rdata_ff <= q_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.run_done) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.pop) begin
         head_ff  <= (head_ff == QPW'(PIXELS - 1)) ? '0 : head_ff + QPW'(1);
         count_ff <= count_ff - QCW'(1);
      end else if (q_push) begin
         tail_ff  <= (tail_ff == QPW'(PIXELS - 1)) ? '0 : tail_ff + QPW'(1);
         count_ff <= count_ff + QCW'(1);
      end
   end

   // walker: columns outer, rows inner
   always_ff @(posedge clock) begin
      if (cmd.center) begin
         j_ff  <= x0;
         k_ff  <= y0;
         y0_ff <= y0;
         xe_ff <= xe;
         ye_ff <= ye;
      end else if (cmd.nb_eval) begin
         if (k_ff == ye_ff) begin
            k_ff <= y0_ff;
            j_ff <= j_ff + XW'(1);
         end else begin
            k_ff <= k_ff + YW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         promoted_ff <= '0;
      end else if (cmd.run_done) begin
         promoted_ff <= '0;
      end else if (nb_mid) begin
         promoted_ff <= promoted_ff + COUNT_W'(1);
      end
   end

   // response register
   logic               rsp_valid_ff;
   class_type          rsp_class_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_status_ff;
   logic               load_direct;

   assign load_direct = cmd.accept && !is_run && !(is_read && in_range);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_direct || cmd.load_read || cmd.run_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_direct) begin
         rsp_class_ff  <= CLS_STRONG;
         rsp_count_ff  <= '0;
         rsp_status_ff <= !in_range;
      end else if (cmd.load_read) begin
         rsp_class_ff  <= s_rdata_ff;
         rsp_count_ff  <= '0;
         rsp_status_ff <= 1'b0;
      end else if (cmd.run_done) begin
         rsp_class_ff  <= CLS_STRONG;
         rsp_count_ff  <= promoted_ff;
         rsp_status_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_class     = rsp_class_ff;
   assign rsp_promoted_count = rsp_count_ff;
   assign rsp_status         = rsp_status_ff;

   assign stat.rsp_valid   = rsp_valid_ff;
   assign stat.is_run      = is_run;
   assign stat.is_read_hit = is_read && in_range;
   assign stat.q_empty     = (count_ff == '0);
   assign stat.nb_empty    = (XE'(x0) >= x1) || (YE'(y0) >= y1);
   assign stat.nb_last     = (k_ff == ye_ff) && (j_ff == xe_ff);

endmodule

@@ design/hysteresis_edge_tracking_top.sv @@
// hysteresis edge tracking: pixel class frame store with breadth first edge growth
// depends on hyst_pkg, hyst_req_if, hyst_rsp_if, hyst_ctrl and hyst_dp
//
// The host loads a class (strong, weak, mid) for every pixel of the active image, queues
// seed pixels, then issues a run. The run takes pixels from the work queue one at a time,
// marks each strong, and promotes and queues every mid pixel among its eight neighbours,
// clipped to the active size; the run response carries the number of promoted pixels.
// Writes and seeds can stream back to back as long as each response is taken; a read's
// response passes through the class store's registered read port and the read wait state.
// In a run each pixel taken from the queue is marked strong, then each neighbour visit
// (at most nine per pixel) reads the class store and then conditionally writes it, in
// separate states, and the run ends with one more look at the empty queue. Input is held
// off for the whole run.
// Pixels must all be written before a run; the store and queue have no reset and need
// no clearing pass. Coordinates outside the active size are ignored and answered with
// status one.
module hysteresis_edge_tracking_top #(
   parameter int MAX_COLUMNS = 512,
   parameter int MAX_ROWS    = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   hyst_req_if.sink                        req_ch,
   hyst_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [hyst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hyst_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hyst_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing: idle, read wait, pop, centre, neighbour read/evaluate
   hyst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .req_ready (req_ch.ready),
      .cmd       (cmd)
   );

   // class store, work queue, walker and response register
   hyst_dp #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_mode           (req_ch.mode),
      .req_x              (req_ch.x_coord),
      .req_y              (req_ch.y_coord),
      .req_class          (req_ch.pixel_class),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_ready          (rsp_ch.ready),
      .stat               (stat),
      .rsp_valid          (rsp_ch.valid),
      .rsp_read_class     (rsp_ch.read_class),
      .rsp_promoted_count (rsp_ch.promoted_count),
      .rsp_status         (rsp_ch.status)
   );

`ifndef SYNTH
   // a run transaction holds off further input
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && stat.is_run) |=> !req_ch.ready)
      else $error("request accepted right after a run transaction");

   // the queue is empty once a run has been answered
   a_run_drains: assert property (@(posedge clock) disable iff (reset)
      cmd.run_done |=> stat.q_empty)
      else $error("work queue not empty after run");

   // read data is loaded into the response register only the cycle after the read transaction
   a_read_timing: assert property (@(posedge clock) disable iff (reset)
      cmd.load_read |-> $past(cmd.accept && stat.is_read_hit))
      else $error("read response without a preceding read transaction");
`endif

endmodule
